[sv/kms_pkg.sv]
// Shared types, constants and sizes for the keypad matrix scanner.
package kms_pkg;

    localparam int ROW_COUNT    = 4;
    localparam int COLUMN_COUNT = 4;
    localparam int KEY_COUNT    = ROW_COUNT * COLUMN_COUNT;
    localparam int LEVEL_BITS   = 4;
    localparam int ROW_W        = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_W        = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int KEY_W        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int COUNT_W      = 16;
    localparam int LIMIT_W      = 15;
    localparam int KEY_INDEX_W  = 4;
    localparam int DRIVE_ROW_W  = 2;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 8;
    localparam int OUT_TUSER_W  = 2;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET   = 15'd10;
    localparam logic [LIMIT_W-1:0] LONG_PRESS_RESET = 15'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_LIMIT   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_LIMIT = 1'b1;

    typedef struct packed {
        logic [LIMIT_W-1:0] debounce;
        logic [LIMIT_W-1:0] long_limit;
    } limits_t;

    typedef struct packed {
        logic hit;
        logic is_long;
    } key_status_t;

    typedef struct packed {
        logic                   event_valid;
        logic                   event_long;
        logic [KEY_INDEX_W-1:0] key_index;
    } result_t;

endpackage

[sv/kms_key_cell.sv]
// Per-key hold counter with debounce and long-press detection.
module kms_key_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pressed,
    input  logic                 update_en,
    input  kms_pkg::limits_t     limits,
    output kms_pkg::key_status_t status
);

    logic [kms_pkg::COUNT_W-1:0] count_reg;
    logic [kms_pkg::COUNT_W-1:0] count_next;
    logic [kms_pkg::COUNT_W-1:0] count_inc;
    logic [kms_pkg::COUNT_W-1:0] twice_long;
    logic [kms_pkg::COUNT_W-1:0] debounce_ext;
    logic [kms_pkg::COUNT_W-1:0] long_ext;
    logic                        short_hit;
    logic                        long_hit;

    assign twice_long   = {limits.long_limit, 1'b0};
    assign debounce_ext = kms_pkg::COUNT_W'(limits.debounce);
    assign long_ext     = kms_pkg::COUNT_W'(limits.long_limit);
    assign count_inc    = (count_reg == kms_pkg::COUNT_MAX) ? count_reg
                                                            : count_reg + 1'b1;

    assign short_hit = (count_reg > debounce_ext) && (count_reg < long_ext);
    assign long_hit  = (count_inc >= long_ext) && (count_inc < twice_long);

    always_comb begin
        if (pressed) begin
            count_next     = long_hit ? twice_long : count_inc;
            status.hit     = long_hit;
            status.is_long = 1'b1;
        end else begin
            count_next     = '0;
            status.hit     = short_hit;
            status.is_long = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (update_en) begin
            count_reg <= count_next;
        end
    end

endmodule

[sv/kms_row_select.sv]
// Column priority walk over the driven row: picks the first reporting key
// and marks which counters of the row take their update.
module kms_row_select (
    input  logic [kms_pkg::ROW_W-1:0] row,
    input  logic                      fire,
    input  kms_pkg::key_status_t      status [kms_pkg::KEY_COUNT],
    output logic                      commit [kms_pkg::KEY_COUNT],
    output kms_pkg::result_t          result
);

    logic [kms_pkg::COLUMN_COUNT-1:0] col_hit;
    logic [kms_pkg::COLUMN_COUNT-1:0] col_long;
    logic [kms_pkg::COLUMN_COUNT-1:0] blocked;
    logic [kms_pkg::COL_W-1:0]        first_col;
    logic                             first_long;
    logic                             any_hit;
    logic [kms_pkg::KEY_W-1:0]        key_sum;

    // gather the driven row's flags by column
    always_comb begin
        col_hit  = '0;
        col_long = '0;
        for (int r = 0; r < kms_pkg::ROW_COUNT; r++) begin
            for (int c = 0; c < kms_pkg::COLUMN_COUNT; c++) begin
                if (row == kms_pkg::ROW_W'(r)) begin
                    col_hit[c]  = status[r*kms_pkg::COLUMN_COUNT + c].hit;
                    col_long[c] = status[r*kms_pkg::COLUMN_COUNT + c].is_long;
                end
            end
        end
    end

    // first report stops the walk; later columns hold their counts
    always_comb begin
        any_hit    = 1'b0;
        first_col  = '0;
        first_long = 1'b0;
        for (int c = 0; c < kms_pkg::COLUMN_COUNT; c++) begin
            blocked[c] = any_hit;
            if (col_hit[c] && !any_hit) begin
                first_col  = kms_pkg::COL_W'(c);
                first_long = col_long[c];
            end
            any_hit = any_hit | col_hit[c];
        end
    end

    always_comb begin
        for (int r = 0; r < kms_pkg::ROW_COUNT; r++) begin
            for (int c = 0; c < kms_pkg::COLUMN_COUNT; c++) begin
                commit[r*kms_pkg::COLUMN_COUNT + c] =
                    fire && (row == kms_pkg::ROW_W'(r)) && !blocked[c];
            end
        end
    end

    assign key_sum = kms_pkg::KEY_W'(row) * kms_pkg::KEY_W'(kms_pkg::COLUMN_COUNT)
                   + kms_pkg::KEY_W'(first_col);

    assign result.event_valid = any_hit;
    assign result.event_long  = any_hit && first_long;
    assign result.key_index   = any_hit ? kms_pkg::KEY_INDEX_W'(key_sum) : '0;

endmodule

[sv/keypad_matrix_scanner_top.sv]
// Top level of the keypad matrix scanner: input register, key cells, result register.
//
//  channel | direction | payload                                  | handshake
//  s_      | in        | tdata[3:0] column_levels                 | s_tvalid/s_tready
//  m_      | out       | tuser event flags, tdata key and row     | m_tvalid/m_tready
//  cfg_    | in        | cfg_index, cfg_data (limits)             | cfg_valid/cfg_ready
//
// One scan tick per cycle while the result is not stalled; a tick goes through
// the input register, then the key-cell update into the result register that presents it.
// aresetn is synchronous: counters, row and valid flags clear, limits load 10/100.
// A stalled result holds the key-cell stage; the input register still takes a
// tick while the result stage is free to drain, so no bubble is inserted.
module keypad_matrix_scanner_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [kms_pkg::IN_TDATA_W-1:0]       s_tdata,   // [3:0] column_levels, [7:4] zero

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [kms_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [3:0] key_index, [5:4] drive_row, [7:6] zero
    output logic [kms_pkg::OUT_TUSER_W-1:0]      m_tuser,   // [0] event_valid, [1] event_long

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [kms_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [kms_pkg::LIMIT_W-1:0]          cfg_data
);

    logic [kms_pkg::LEVEL_BITS-1:0]  levels_reg;
    logic                            in_valid_reg;
    logic [kms_pkg::ROW_W-1:0]       scan_row_reg;
    logic [kms_pkg::ROW_W-1:0]       scan_row_next;
    logic                            out_valid_reg;
    kms_pkg::result_t                result_reg;
    kms_pkg::result_t                result_next;
    logic [kms_pkg::DRIVE_ROW_W-1:0] drive_row_reg;
    kms_pkg::limits_t                limits_reg;
    logic                            advance;
    logic                            fire;
    kms_pkg::key_status_t            status [kms_pkg::KEY_COUNT];
    logic                            commit [kms_pkg::KEY_COUNT];

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;

    assign scan_row_next = (scan_row_reg == kms_pkg::ROW_W'(kms_pkg::ROW_COUNT - 1))
                         ? '0 : scan_row_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.debounce   <= kms_pkg::DEBOUNCE_RESET;
            limits_reg.long_limit <= kms_pkg::LONG_PRESS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                kms_pkg::CFG_DEBOUNCE_LIMIT:   limits_reg.debounce   <= cfg_data;
                kms_pkg::CFG_LONG_PRESS_LIMIT: limits_reg.long_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            levels_reg <= s_tdata[kms_pkg::LEVEL_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_row_reg <= '0;
        end else if (fire) begin
            scan_row_reg <= scan_row_next;
        end
    end

    for (genvar r = 0; r < kms_pkg::ROW_COUNT; r++) begin : g_row
        for (genvar c = 0; c < kms_pkg::COLUMN_COUNT; c++) begin : g_col
            logic key_pressed;
            // columns beyond the input bits read as released
            if (c < kms_pkg::LEVEL_BITS) begin : g_level
                assign key_pressed = !levels_reg[c];
            end else begin : g_open
                assign key_pressed = 1'b0;
            end

            kms_key_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .pressed   (key_pressed),
                .update_en (commit[r*kms_pkg::COLUMN_COUNT + c]),
                .limits    (limits_reg),
                .status    (status[r*kms_pkg::COLUMN_COUNT + c])
            );
        end
    end

    kms_row_select u_row_select (
        .row    (scan_row_reg),
        .fire   (fire),
        .status (status),
        .commit (commit),
        .result (result_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg    <= result_next;
            drive_row_reg <= kms_pkg::DRIVE_ROW_W'(scan_row_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {result_reg.event_long, result_reg.event_valid};
    assign m_tdata  = {{(kms_pkg::OUT_TDATA_W - kms_pkg::KEY_INDEX_W
                         - kms_pkg::DRIVE_ROW_W){1'b0}},
                       drive_row_reg, result_reg.key_index};

    a_row_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> scan_row_reg == $past(scan_row_next))
        else $error("scan row did not advance on a processed tick");

    a_row_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(scan_row_reg))
        else $error("scan row moved without a processed tick");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(result_reg) && $stable(drive_row_reg))
        else $error("stalled result changed");

    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !result_next.event_valid) |=>
            (!result_reg.event_long && (result_reg.key_index == '0)))
        else $error("event fields not cleared for a tick without a report");

    a_event_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && result_next.event_valid) |->
            commit[kms_pkg::KEY_W'(result_next.key_index)])
        else $error("reported key did not take its counter update");

endmodule
